// ----- rtl/fohdm_pkg.sv -----
// Shared types, widths and the quarter-wave sine table for the X-drive mixer.
// No dependencies.
`default_nettype none
package fohdm_pkg;

    localparam int FRAC_BITS = 8;
    localparam int NW = 55;                 // |n| * max_power
    localparam int DW = 48;                 // divisor, |n| and limit
    localparam int QB = 7 + FRAC_BITS;      // quotient bits
    localparam int RW = 57 + FRAC_BITS;     // partial remainder
    localparam int EW = (QB > 17) ? QB : 17;

    localparam logic [14:0] QSINE [0:90] = '{
        15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
        15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
        15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
        15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
        15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
        15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
        15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421, 15'd13583,
        15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466, 15'd14598,
        15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396,
        15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
        15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    typedef struct packed {
        logic                   valid;
        logic [3:0][NW-1:0]     num;
        logic [DW-1:0]          den;
        logic [3:0]             neg;
        logic [3:0]             zero;
    } fohdm_div_in_t;

    typedef struct packed {
        logic                   valid;
        logic [3:0][QB-1:0]     quo;
        logic [3:0]             neg;
        logic [3:0]             zero;
    } fohdm_div_out_t;

endpackage
`default_nettype wire

// ----- rtl/field_oriented_holonomic_drive_mixer_unit.sv -----
// Top level of the field-oriented X-drive mixer: config registers, pipeline, output stage.
// Depends on fohdm_pkg, fohdm_front and fohdm_div.
//
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          forward, strafe, rotate, heading
// m_axis    out  tvalid/tready          four wheel powers
// cfg       in   valid/ready            index, data
//
// One word per cycle sustained while m_axis accepts; a word passes through the
// seven front stages and the one-bit-per-stage divider.
// Reset clears the valid bits and loads field_oriented = 1, max_power = 100.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module field_oriented_holonomic_drive_mixer_unit
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [39:0]    s_axis_tdata,   // forward_axis, strafe_axis, rotate_axis, heading_deg
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [63:0]         m_axis_tdata,   // left front, left rear, right front, right rear
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic           cfg_index,
    input  wire logic [6:0]     cfg_data
);
    import fohdm_pkg::*;

    localparam logic CFG_FIELD_ORIENTED = 1'b0;
    localparam logic CFG_MAX_POWER = 1'b1;

    logic           fo_reg;
    logic [6:0]     mp_reg;
    logic           adv;
    logic           out_valid_reg;
    logic [63:0]    out_data_reg;
    logic [63:0]    out_data_next;
    fohdm_div_in_t  div_in;
    fohdm_div_out_t div_out;

    assign adv = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fo_reg <= 1'b1;
            mp_reg <= 7'd100;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FIELD_ORIENTED: fo_reg <= cfg_data[0];
                CFG_MAX_POWER:      mp_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    fohdm_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .in_valid       (s_axis_tvalid),
        .forward_axis   ($signed(s_axis_tdata[7:0])),
        .strafe_axis    ($signed(s_axis_tdata[15:8])),
        .rotate_axis    ($signed(s_axis_tdata[23:16])),
        .heading_deg    (s_axis_tdata[32:24]),
        .field_oriented (fo_reg),
        .max_power      (mp_reg),
        .div_in         (div_in)
    );

    fohdm_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .div_in  (div_in),
        .div_out (div_out)
    );

    always_comb
    begin
        logic [EW-1:0] qe;
        for (int i = 0; i < 4; i++)
        begin
            qe = EW'(div_out.quo[i]);
            if (div_out.zero[i])
                out_data_next[16*i +: 16] = 16'd0;
            else if (div_out.neg[i])
                out_data_next[16*i +: 16] = (qe > EW'(32768)) ? 16'h8000 : 16'(-qe);
            else
                out_data_next[16*i +: 16] = (qe > EW'(32767)) ? 16'h7FFF : 16'(qe);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= div_out.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

endmodule
`default_nettype wire

// ----- rtl/fohdm_front.sv -----
// Front pipeline: heading reduction, sine/cosine, axis rotation, mixing, limit.
// Depends on fohdm_pkg.
`default_nettype none
module fohdm_front
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire logic                   in_valid,
    input  wire logic signed [7:0]      forward_axis,
    input  wire logic signed [7:0]      strafe_axis,
    input  wire logic signed [7:0]      rotate_axis,
    input  wire logic [8:0]             heading_deg,
    input  wire logic                   field_oriented,
    input  wire logic [6:0]             max_power,
    output fohdm_pkg::fohdm_div_in_t    div_in
);
    import fohdm_pkg::*;

    // stage 1: quadrant and angle
    logic               v1_reg;
    logic signed [7:0]  f1_reg, s1_reg, r1_reg;
    logic [1:0]         q1_reg;
    logic [6:0]         d1_reg;
    logic [8:0]         h_next;
    logic [1:0]         q1_next;
    logic [6:0]         d1_next;

    always_comb
    begin
        h_next = (heading_deg >= 9'd360) ? heading_deg - 9'd360 : heading_deg;
        if (h_next < 9'd90)
        begin
            q1_next = 2'd0;
            d1_next = h_next[6:0];
        end
        else if (h_next < 9'd180)
        begin
            q1_next = 2'd1;
            d1_next = 7'(h_next - 9'd90);
        end
        else if (h_next < 9'd270)
        begin
            q1_next = 2'd2;
            d1_next = 7'(h_next - 9'd180);
        end
        else
        begin
            q1_next = 2'd3;
            d1_next = 7'(h_next - 9'd270);
        end
    end

    // stage 2: sine and cosine
    logic               v2_reg;
    logic signed [7:0]  f2_reg, s2_reg, r2_reg;
    logic signed [15:0] sn2_reg, cs2_reg;
    logic signed [15:0] ta, tb, sn2_next, cs2_next;

    always_comb
    begin
        ta = $signed({1'b0, QSINE[d1_reg]});
        tb = $signed({1'b0, QSINE[7'd90 - d1_reg]});
        case (q1_reg)
            2'd0:
            begin
                sn2_next = ta;
                cs2_next = tb;
            end
            2'd1:
            begin
                sn2_next = tb;
                cs2_next = -ta;
            end
            2'd2:
            begin
                sn2_next = -ta;
                cs2_next = -tb;
            end
            default:
            begin
                sn2_next = -tb;
                cs2_next = ta;
            end
        endcase
    end

    // stage 3: rotated axes, Q14
    logic               v3_reg;
    logic signed [7:0]  r3_reg;
    logic signed [23:0] fq3_reg, sq3_reg;
    logic signed [23:0] pfc, pss, pfs, psc, fq3_next, sq3_next;

    always_comb
    begin
        pfc = 24'(f2_reg) * 24'(cs2_reg);
        pss = 24'(s2_reg) * 24'(sn2_reg);
        pfs = 24'(f2_reg) * 24'(sn2_reg);
        psc = 24'(s2_reg) * 24'(cs2_reg);
        if (field_oriented)
        begin
            fq3_next = pfc + pss;
            sq3_next = psc - pfs;
        end
        else
        begin
            fq3_next = {{2{f2_reg[7]}}, f2_reg, 14'd0};
            sq3_next = {{2{s2_reg[7]}}, s2_reg, 14'd0};
        end
    end

    // stage 4: sum and max of magnitudes, raw wheel sums
    logic               v4_reg;
    logic signed [7:0]  r4_reg;
    logic [23:0]        a4_reg;
    logic [22:0]        m4_reg;
    logic signed [24:0] w0_4_reg, w1_4_reg;
    logic [23:0]        fabs, sabs;
    logic [23:0]        a4_next;
    logic [22:0]        m4_next;

    always_comb
    begin
        fabs = fq3_reg[23] ? 24'(-fq3_reg) : 24'(fq3_reg);
        sabs = sq3_reg[23] ? 24'(-sq3_reg) : 24'(sq3_reg);
        a4_next = fabs + sabs;
        m4_next = (fabs > sabs) ? fabs[22:0] : sabs[22:0];
        if (a4_next == 24'd0)
        begin
            a4_next = 24'd1;
            m4_next = 23'd0;
        end
    end

    // stage 5: products
    logic               v5_reg;
    logic signed [48:0] p0_5_reg, p1_5_reg, ra5_reg;
    logic [DW-1:0]      lim5_reg;
    logic signed [48:0] p0_next, p1_next;
    logic signed [32:0] ra_prod;
    logic [30:0]        lim_prod;

    always_comb
    begin
        p0_next = 49'(w0_4_reg) * $signed({26'd0, m4_reg});
        p1_next = 49'(w1_4_reg) * $signed({26'd0, m4_reg});
        ra_prod = 33'(r4_reg) * $signed({9'd0, a4_reg});
        lim_prod = 31'(max_power) * 31'(a4_reg);
    end

    // stage 6: wheel numerators
    logic               v6_reg;
    logic [3:0][DW-1:0] mag6_reg;
    logic [3:0]         neg6_reg;
    logic [DW-1:0]      lim6_reg;
    logic signed [48:0] n_next [4];
    logic [3:0][DW-1:0] mag6_next;

    always_comb
    begin
        n_next[0] = p0_5_reg + ra5_reg;
        n_next[1] = p1_5_reg + ra5_reg;
        n_next[2] = p1_5_reg - ra5_reg;
        n_next[3] = p0_5_reg - ra5_reg;
        for (int i = 0; i < 4; i++)
            mag6_next[i] = n_next[i][48] ? DW'(-n_next[i]) : DW'(n_next[i]);
    end

    // stage 7: divisor and dividends
    fohdm_div_in_t  div_reg;
    logic [DW-1:0]  mx01, mx23, mxall;

    always_comb
    begin
        mx01 = (mag6_reg[0] > mag6_reg[1]) ? mag6_reg[0] : mag6_reg[1];
        mx23 = (mag6_reg[2] > mag6_reg[3]) ? mag6_reg[2] : mag6_reg[3];
        mxall = (mx01 > mx23) ? mx01 : mx23;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            div_reg <= '0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            div_reg.valid <= v6_reg;
            div_reg.den <= (mxall > lim6_reg) ? mxall : lim6_reg;
            for (int i = 0; i < 4; i++)
            begin
                div_reg.num[i] <= NW'(mag6_reg[i]) * NW'(max_power);
                div_reg.neg[i] <= neg6_reg[i];
                div_reg.zero[i] <= (mag6_reg[i] == '0) || (max_power == 7'd0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg <= forward_axis;
            s1_reg <= strafe_axis;
            r1_reg <= rotate_axis;
            q1_reg <= q1_next;
            d1_reg <= d1_next;

            f2_reg <= f1_reg;
            s2_reg <= s1_reg;
            r2_reg <= r1_reg;
            sn2_reg <= sn2_next;
            cs2_reg <= cs2_next;

            r3_reg <= r2_reg;
            fq3_reg <= fq3_next;
            sq3_reg <= sq3_next;

            r4_reg <= r3_reg;
            a4_reg <= a4_next;
            m4_reg <= m4_next;
            w0_4_reg <= 25'(fq3_reg) + 25'(sq3_reg);
            w1_4_reg <= 25'(fq3_reg) - 25'(sq3_reg);

            p0_5_reg <= p0_next;
            p1_5_reg <= p1_next;
            ra5_reg <= {{2{ra_prod[32]}}, ra_prod, 14'd0};
            lim5_reg <= {3'd0, lim_prod, 14'd0};

            mag6_reg <= mag6_next;
            for (int i = 0; i < 4; i++)
                neg6_reg[i] <= n_next[i][48];
            lim6_reg <= lim5_reg;
        end
    end

    assign div_in = div_reg;

endmodule
`default_nettype wire

// ----- rtl/fohdm_div.sv -----
// Restoring divider pipeline, one quotient bit per stage, four lanes.
// Depends on fohdm_pkg.
`default_nettype none
module fohdm_div
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  fohdm_pkg::fohdm_div_in_t    div_in,
    output fohdm_pkg::fohdm_div_out_t   div_out
);
    import fohdm_pkg::*;

    logic                   v_reg   [0:QB];
    logic [3:0][RW-1:0]     rem_reg [0:QB];
    logic [3:0][QB-1:0]     quo_reg [0:QB];
    logic [DW-1:0]          den_reg [0:QB];
    logic [3:0]             neg_reg [0:QB];
    logic [3:0]             zero_reg [0:QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv)
            v_reg[0] <= div_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rem_reg[0][i] <= RW'(div_in.num[i]) << FRAC_BITS;
                quo_reg[0][i] <= '0;
            end
            den_reg[0] <= div_in.den;
            neg_reg[0] <= div_in.neg;
            zero_reg[0] <= div_in.zero;
        end
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_stage
        localparam int K = QB - 1 - j;
        logic [RW-1:0]      dsh;
        logic [3:0][RW-1:0] rem_next;
        logic [3:0][QB-1:0] quo_next;

        always_comb
        begin
            dsh = RW'(den_reg[j]) << K;
            for (int i = 0; i < 4; i++)
            begin
                if (rem_reg[j][i] >= dsh)
                begin
                    rem_next[i] = rem_reg[j][i] - dsh;
                    quo_next[i] = {quo_reg[j][i][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = rem_reg[j][i];
                    quo_next[i] = {quo_reg[j][i][QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j+1] <= 1'b0;
            else if (adv)
                v_reg[j+1] <= v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j+1] <= rem_next;
                quo_reg[j+1] <= quo_next;
                den_reg[j+1] <= den_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                zero_reg[j+1] <= zero_reg[j];
            end
        end
    end

    assign div_out.valid = v_reg[QB];
    assign div_out.quo = quo_reg[QB];
    assign div_out.neg = neg_reg[QB];
    assign div_out.zero = zero_reg[QB];

endmodule
`default_nettype wire

// ----- tb/field_oriented_holonomic_drive_mixer_unit_check.sv -----
// Scoreboard for the X-drive mixer: tracks config writes, predicts wheel powers
// per accepted input word and compares output words in order. Uses fohdm_pkg.
`default_nettype none
module field_oriented_holonomic_drive_mixer_unit_check
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    input  wire logic           s_axis_tready,
    input  wire logic [39:0]    s_axis_tdata,
    input  wire logic           m_axis_tvalid,
    input  wire logic           m_axis_tready,
    input  wire logic [63:0]    m_axis_tdata,
    input  wire logic           cfg_valid,
    input  wire logic           cfg_ready,
    input  wire logic           cfg_index,
    input  wire logic [6:0]     cfg_data,
    output int                  wheel_errors,
    output int                  wheels_pending,
    output int                  words_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import fohdm_pkg::*;

    localparam longint QONE = 16384;

    bit          orient_on;
    bit [6:0]    power_cap;
    logic [63:0] wheel_fifo [$];

    function automatic longint absl(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [63:0] mix_wheels(input bit fo, input bit [6:0] cap,
                                               input logic [39:0] d);
        longint f, s, r, sn, cs, fq, sq, a, m, rq, nmax, lim, den, num, q0, r0, qv, res;
        longint w [4];
        longint n [4];
        int h, d90, a0, b0;
        logic [63:0] o;
        f = longint'($signed(d[7:0]));
        s = longint'($signed(d[15:8]));
        r = longint'($signed(d[23:16]));
        h = int'(d[32:24]) % 360;
        d90 = h % 90;
        a0 = int'(QSINE[d90]);
        b0 = int'(QSINE[90 - d90]);
        case (h / 90)
            0: begin sn = a0;  cs = b0;  end
            1: begin sn = b0;  cs = -a0; end
            2: begin sn = -a0; cs = -b0; end
            default: begin sn = -b0; cs = a0; end
        endcase
        if (fo)
        begin
            fq = f * cs + s * sn;
            sq = -f * sn + s * cs;
        end
        else
        begin
            fq = f * QONE;
            sq = s * QONE;
        end
        a = absl(fq) + absl(sq);
        m = (absl(fq) > absl(sq)) ? absl(fq) : absl(sq);
        if (a == 0)
        begin
            a = 1;
            m = 0;
        end
        rq = r * QONE;
        w[0] = fq + sq;
        w[1] = fq - sq;
        w[2] = fq - sq;
        w[3] = fq + sq;
        n[0] = w[0] * m + rq * a;
        n[1] = w[1] * m + rq * a;
        n[2] = w[2] * m - rq * a;
        n[3] = w[3] * m - rq * a;
        nmax = 0;
        for (int i = 0; i < 4; i++)
            if (absl(n[i]) > nmax)
                nmax = absl(n[i]);
        lim = longint'(cap) * QONE * a;
        den = (nmax > lim) ? nmax : lim;
        for (int i = 0; i < 4; i++)
        begin
            res = 0;
            if (den != 0)
            begin
                num = absl(n[i]) * longint'(cap);
                q0 = num / den;
                r0 = num % den;
                qv = (q0 << FRAC_BITS) + ((r0 << FRAC_BITS) / den);
                if (qv > 32768)
                    qv = 32768;
                res = (n[i] < 0) ? -qv : qv;
                if (res > 32767)
                    res = 32767;
            end
            o[16*i +: 16] = res[15:0];
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_on = 1'b1;
            power_cap = 7'd100;
            wheel_fifo.delete();
            wheel_errors = 0;
            words_checked = 0;
            wheels_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == 1'b0)
                    orient_on = cfg_data[0];
                else
                    power_cap = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                wheel_fifo.push_back(mix_wheels(orient_on, power_cap, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (wheel_fifo.size() == 0)
                begin
                    $error("unexpected output word %h", m_axis_tdata);
                    wheel_errors++;
                end
                else
                begin
                    logic [63:0] exp_w;
                    exp_w = wheel_fifo.pop_front();
                    words_checked++;
                    if (m_axis_tdata[15:0] !== exp_w[15:0])
                    begin
                        $error("left_front_power: expected %0d, got %0d",
                               $signed(exp_w[15:0]), $signed(m_axis_tdata[15:0]));
                        wheel_errors++;
                    end
                    if (m_axis_tdata[31:16] !== exp_w[31:16])
                    begin
                        $error("left_rear_power: expected %0d, got %0d",
                               $signed(exp_w[31:16]), $signed(m_axis_tdata[31:16]));
                        wheel_errors++;
                    end
                    if (m_axis_tdata[47:32] !== exp_w[47:32])
                    begin
                        $error("right_front_power: expected %0d, got %0d",
                               $signed(exp_w[47:32]), $signed(m_axis_tdata[47:32]));
                        wheel_errors++;
                    end
                    if (m_axis_tdata[63:48] !== exp_w[63:48])
                    begin
                        $error("right_rear_power: expected %0d, got %0d",
                               $signed(exp_w[63:48]), $signed(m_axis_tdata[63:48]));
                        wheel_errors++;
                    end
                end
            end
            wheels_pending = wheel_fifo.size();
        end
    end
endmodule
`default_nettype wire

// ----- tb/field_oriented_holonomic_drive_mixer_unit_test.sv -----
// Top of the X-drive mixer testbench: clock, reset, stimulus, config phases, verdict.
// Depends on fohdm_pkg, the mixer RTL and field_oriented_holonomic_drive_mixer_unit_check.
`default_nettype none
module field_oriented_holonomic_drive_mixer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [6:0]  cfg_data = '0;
    int          wheel_errors, wheels_pending, words_checked;
    int          burst_left = 0;
    int          stall_mode = 0;

    always #4 clk = ~clk;

    field_oriented_holonomic_drive_mixer_unit dut (.*);

    field_oriented_holonomic_drive_mixer_unit_check chk (.*);

    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= $urandom_range(0, 1);
        endcase
    end

    task automatic send_cmd(input logic [7:0] f, input logic [7:0] s,
                            input logic [7:0] r, input logic [8:0] h);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, h, r, s, f};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain_out();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (wheels_pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] val);
        drain_out();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        logic [7:0] f, s, r;
        logic [8:0] h;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                f = 8'($urandom);
                s = 8'($urandom);
                r = 8'($urandom);
                h = 9'($urandom);
            end
            else
            begin
                f = 8'($urandom_range(0, 200) - 100);
                s = 8'($urandom_range(0, 200) - 100);
                r = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 200) - 100);
                h = 9'($urandom_range(0, 359));
            end
            send_cmd(f, s, r, h);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // defaults: field oriented, cap 100
        send_cmd(8'd0, 8'd0, 8'd0, 9'd0);
        send_cmd(8'd127, 8'd127, 8'd127, 9'd0);
        send_cmd(8'h80, 8'h80, 8'h80, 9'd90);
        send_cmd(8'd100, 8'd0, 8'd0, 9'd180);
        send_cmd(8'd0, 8'd100, 8'd0, 9'd270);
        send_cmd(8'd0, 8'd0, 8'd100, 9'd359);
        send_cmd(8'd50, 8'h9c, 8'h80, 9'd360);
        send_cmd(8'h80, 8'd127, 8'd0, 9'd511);
        send_cmd(8'd100, 8'd100, 8'd100, 9'd45);
        send_cmd(8'h9c, 8'd100, 8'd0, 9'd450);

        write_reg(1'b0, 7'd0);
        write_reg(1'b1, 7'd127);
        send_cmd(8'd127, 8'd127, 8'd127, 9'd37);
        send_cmd(8'h80, 8'd0, 8'd127, 9'd0);
        send_cmd(8'd0, 8'd0, 8'd0, 9'd200);
        send_cmd(8'd30, 8'h90, 8'd5, 9'd300);

        write_reg(1'b1, 7'd0);
        send_cmd(8'd100, 8'd50, 8'd20, 9'd10);
        send_cmd(8'h80, 8'h80, 8'h80, 9'd511);

        write_reg(1'b1, 7'd1);
        send_cmd(8'd100, 8'd50, 8'd20, 9'd10);
        send_cmd(8'd1, 8'd0, 8'd0, 9'd0);

        write_reg(1'b0, 7'h7f);
        write_reg(1'b1, 7'd100);
        send_cmd(8'd64, 8'h40, 8'd0, 9'd135);
        send_cmd(8'd0, 8'd0, 8'h9c, 9'd225);

        for (int p = 0; p < 6; p++)
        begin
            write_reg(1'b0, 7'($urandom));
            write_reg(1'b1, (p == 0) ? 7'd127 : (p == 1) ? 7'd1 : 7'($urandom));
            send_random(310);
        end

        drain_out();
        repeat (40) @(negedge clk);
        $display("Checked %0d output words over directed extremes and six random config phases,",
                 words_checked);
        $display("with bursty input and random output stalls.");
        if (wheel_errors == 0 && wheels_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
